// ----- src/jtl_pkg.sv -----
// Shared types, codes and byte-class helpers for the JSON token lexer.
package jtl_pkg;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_STRING  = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_LITERAL = 5'b01000,
        MODE_ERROR   = 5'b10000
    } t_mode;

    localparam logic [3:0] KIND_LBRACE   = 4'd0;
    localparam logic [3:0] KIND_RBRACE   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_COLON    = 4'd4;
    localparam logic [3:0] KIND_COMMA    = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd7;
    localparam logic [3:0] KIND_TRUE     = 4'd8;
    localparam logic [3:0] KIND_FALSE    = 4'd9;
    localparam logic [3:0] KIND_NULL     = 4'd10;
    localparam logic [3:0] KIND_NONE     = 4'd11;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [3:0] kind;
        logic       cv;
        logic [7:0] cb;
        logic       comp;
        logic       err;
        logic       fin;
        logic       last;
    } t_result;

    typedef struct packed {
        logic       emit;
        t_result    res;
        t_mode      mode;
        logic       lit_start;
        logic [1:0] which;
    } t_idle;

    function automatic t_result make_res(input logic [3:0] kind, input logic cv,
                                         input logic [7:0] cb, input logic comp,
                                         input logic err, input logic fin);
        t_result r;
        r.kind = kind;
        r.cv   = cv;
        r.cb   = cv ? cb : 8'd0;
        r.comp = comp;
        r.err  = err;
        r.fin  = fin;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_number_char(input logic [7:0] b);
        return is_digit(b) || b == CH_DOT || b == CH_E || b == CH_UPPER_E ||
               b == CH_PLUS || b == CH_MINUS;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] which);
        return (which == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    // Expected byte at a position of a literal; out-of-range reads as zero.
    function automatic logic [7:0] lit_char(input logic [1:0] which,
                                            input logic [2:0] pos);
        logic [7:0] c;
        c = CH_NUL;
        unique case (which)
            LIT_FALSE: begin
                unique case (pos)
                    3'd0:    c = CH_F;
                    3'd1:    c = CH_A;
                    3'd2:    c = CH_L;
                    3'd3:    c = CH_S;
                    3'd4:    c = CH_E;
                    default: c = CH_NUL;
                endcase
            end
            LIT_NULL: begin
                unique case (pos)
                    3'd0:    c = CH_N;
                    3'd1:    c = CH_U;
                    3'd2:    c = CH_L;
                    3'd3:    c = CH_L;
                    default: c = CH_NUL;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    c = CH_T;
                    3'd1:    c = CH_R;
                    3'd2:    c = CH_U;
                    3'd3:    c = CH_E;
                    default: c = CH_NUL;
                endcase
            end
        endcase
        return c;
    endfunction

    // Lex one byte from between tokens.
    function automatic t_idle lex_idle(input logic [7:0] b);
        t_idle o;
        o.emit      = 1'b0;
        o.res       = make_res(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        o.mode      = MODE_IDLE;
        o.lit_start = 1'b0;
        o.which     = LIT_TRUE;
        unique case (b)
            CH_NUL: begin
                o.emit = 1'b1;
                o.res  = make_res(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
            end
            CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                o.emit = 1'b0;
            end
            CH_LBRACE: begin
                o.emit = 1'b1;
                o.res  = make_res(KIND_LBRACE, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            end
            CH_RBRACE: begin
                o.emit = 1'b1;
                o.res  = make_res(KIND_RBRACE, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            end
            CH_LBRACKET: begin
                o.emit = 1'b1;
                o.res  = make_res(KIND_LBRACKET, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            end
            CH_RBRACKET: begin
                o.emit = 1'b1;
                o.res  = make_res(KIND_RBRACKET, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            end
            CH_COLON: begin
                o.emit = 1'b1;
                o.res  = make_res(KIND_COLON, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            end
            CH_COMMA: begin
                o.emit = 1'b1;
                o.res  = make_res(KIND_COMMA, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            end
            CH_QUOTE: begin
                o.mode = MODE_STRING;
            end
            CH_T: begin
                o.mode      = MODE_LITERAL;
                o.lit_start = 1'b1;
                o.which     = LIT_TRUE;
            end
            CH_F: begin
                o.mode      = MODE_LITERAL;
                o.lit_start = 1'b1;
                o.which     = LIT_FALSE;
            end
            CH_N: begin
                o.mode      = MODE_LITERAL;
                o.lit_start = 1'b1;
                o.which     = LIT_NULL;
            end
            default: begin
                o.emit = 1'b1;
                if (is_digit(b) || b == CH_MINUS) begin
                    o.mode = MODE_NUMBER;
                    o.res  = make_res(KIND_NUMBER, 1'b1, b, 1'b0, 1'b0, 1'b0);
                end else begin
                    o.mode = MODE_ERROR;
                    o.res  = make_res(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0);
                end
            end
        endcase
        return o;
    endfunction

endpackage

// ----- src/json_token_lexer.sv -----
// Streaming JSON lexer: one text byte in, zero to two token beats out.
//
// The lexer takes one text byte per cycle, while the output queue has room for
// its results, and turns it into token beats: punctuation, string and number
// content byte by byte, the literals true, false and null, end-of-text and
// error markers. A byte is captured in an input register, lexed against the
// mode state combinationally, and its results are written to a two-entry
// output queue, from which the first result is offered. Bytes that give at
// most one result stream at one per cycle while the output side keeps up; a
// byte that gives two results (the byte that closes a number and is itself a
// token, an invalid byte or the end of text, or a zero inside a string) waits
// until the queue has room for both, counting the beat that leaves in the
// same cycle. The input side keeps accepting bytes only while the output queue
// has room for their results.
module json_token_lexer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_text_valid,
    output logic                o_text_ready,
    input  logic [7:0]          i_text_byte,
    output logic                o_token_valid,
    input  logic                i_token_ready,
    output logic [3:0]          o_token_kind,
    output logic                o_content_valid,
    output logic [7:0]          o_content_byte,
    output logic                o_token_complete,
    output logic                o_lex_error,
    output logic                o_text_finished,
    output logic                o_last_of_run
);
    import jtl_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_mode       r_mode,    n_mode;
    logic [1:0]  r_lit_which, n_lit_which;
    logic [2:0]  r_lit_pos,   n_lit_pos;
    t_result     r_q [2];
    t_result     n_q [2];
    logic [1:0]  r_cnt, n_cnt;

    t_result     res0, res1;
    logic [1:0]  k;
    t_idle       idl;
    logic [1:0]  w;
    logic        lit_match;
    logic [2:0]  pos_inc;
    logic        consume;
    logic        pop;

    // Lex the captured byte against the current mode.
    always_comb begin
        res0        = make_res(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        res1        = make_res(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        k           = 2'd0;
        n_mode      = r_mode;
        n_lit_which = r_lit_which;
        n_lit_pos   = r_lit_pos;
        idl         = lex_idle(r_in_byte);
        w           = (r_lit_which == 2'd3) ? LIT_TRUE : r_lit_which;
        lit_match   = (r_lit_pos < lit_len(w)) && (r_in_byte == lit_char(w, r_lit_pos));
        pos_inc     = r_lit_pos + 3'd1;
        unique case (r_mode)
            MODE_STRING: begin
                if (r_in_byte == CH_QUOTE) begin
                    n_mode = MODE_IDLE;
                    res0   = make_res(KIND_STRING, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    k      = 2'd1;
                end else if (r_in_byte == CH_NUL) begin
                    n_mode = MODE_IDLE;
                    res0   = make_res(KIND_STRING, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    res1   = make_res(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
                    k      = 2'd2;
                end else begin
                    res0 = make_res(KIND_STRING, 1'b1, r_in_byte, 1'b0, 1'b0, 1'b0);
                    k    = 2'd1;
                end
            end
            MODE_NUMBER: begin
                if (is_number_char(r_in_byte)) begin
                    res0 = make_res(KIND_NUMBER, 1'b1, r_in_byte, 1'b0, 1'b0, 1'b0);
                    k    = 2'd1;
                end else begin
                    // Close the number, then lex the same byte from idle.
                    res0   = make_res(KIND_NUMBER, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    res1   = idl.res;
                    k      = idl.emit ? 2'd2 : 2'd1;
                    n_mode = idl.mode;
                    if (idl.lit_start) begin
                        n_lit_which = idl.which;
                        n_lit_pos   = 3'd1;
                    end
                end
            end
            MODE_LITERAL: begin
                k = 2'd0;
                if (lit_match) begin
                    n_lit_pos = pos_inc;
                    if (pos_inc >= lit_len(w)) begin
                        n_mode = MODE_IDLE;
                        res0   = make_res(KIND_TRUE + {2'b00, w}, 1'b0, 8'd0,
                                          1'b1, 1'b0, 1'b0);
                        k      = 2'd1;
                    end
                end else begin
                    n_mode = (r_in_byte == CH_NUL) ? MODE_IDLE : MODE_ERROR;
                    res0   = make_res(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b1,
                                      r_in_byte == CH_NUL);
                    k      = 2'd1;
                end
            end
            MODE_ERROR: begin
                if (r_in_byte == CH_NUL) begin
                    n_mode = MODE_IDLE;
                    res0   = make_res(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
                    k      = 2'd1;
                end
            end
            default: begin
                res0   = idl.res;
                k      = idl.emit ? 2'd1 : 2'd0;
                n_mode = idl.mode;
                if (idl.lit_start) begin
                    n_lit_which = idl.which;
                    n_lit_pos   = 3'd1;
                end
            end
        endcase
        if (k == 2'd1) begin
            res0.last = 1'b1;
        end
        if (k == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    // Take the byte only when the queue has room for all its results,
    // counting the beat that leaves this cycle.
    assign consume      = r_in_valid &&
                          (({1'b0, r_cnt} - {2'b00, pop} + {1'b0, k}) <= 3'd2);
    assign o_text_ready = !r_in_valid || consume;
    assign pop          = (r_cnt != 2'd0) && i_token_ready;

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_cnt  = r_cnt - 2'd1;
        end
        if (consume) begin
            unique case (k)
                2'd1: begin
                    n_q[n_cnt[0]] = res0;
                end
                2'd2: begin
                    n_q[0] = res0;
                    n_q[1] = res1;
                end
                default: begin
                    n_q[0] = n_q[0];
                end
            endcase
            n_cnt = n_cnt + k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_lit_which <= LIT_TRUE;
            r_lit_pos   <= 3'd0;
            r_cnt       <= 2'd0;
        end else begin
            if (o_text_ready) begin
                r_in_valid <= i_text_valid;
            end
            if (consume) begin
                r_mode      <= n_mode;
                r_lit_which <= n_lit_which;
                r_lit_pos   <= n_lit_pos;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_text_ready && i_text_valid) begin
            r_in_byte <= i_text_byte;
        end
        r_q <= n_q;
    end

    assign o_token_valid    = (r_cnt != 2'd0);
    assign o_token_kind     = r_q[0].kind;
    assign o_content_valid  = r_q[0].cv;
    assign o_content_byte   = r_q[0].cb;
    assign o_token_complete = r_q[0].comp;
    assign o_lex_error      = r_q[0].err;
    assign o_text_finished  = r_q[0].fin;
    assign o_last_of_run    = r_q[0].last;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_pair_needs_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && k == 2'd2) |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)))
        else $error("two-result byte pushed into a non-empty queue");

    a_lit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_LITERAL) |-> (r_lit_pos != 3'd0 && r_lit_pos <= 3'd4))
        else $error("literal position out of range in literal mode");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost before it was lexed");

    a_mode_static: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !consume |=> $stable(r_mode))
        else $error("mode changed without a consumed byte");
`endif

endmodule

// ----- tb/sv/tb_json_token_lexer.sv -----
// Self-checking testbench for the JSON token lexer: directed table, then random text.
module tb_json_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    import jtl_pkg::*;

    localparam int         HOLD_CYCLES   = 80;
    localparam int         PHASE_BYTES   = 316;
    localparam int         DRAIN_LIMIT   = 5000;
    localparam int         MAX_REPORTS   = 10;
    localparam logic [7:0] CH_AT         = 8'h40;
    localparam logic [7:0] CH_HIGH       = 8'hFF;
    localparam logic [7:0] CH_TOP_BIT    = 8'h80;
    localparam t_result    NO_TOK        = '0;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_text_valid    = 1'b0;
    logic [7:0] i_text_byte     = 8'd0;
    logic       i_token_ready   = 1'b0;
    logic       o_text_ready;
    logic       o_token_valid;
    logic [3:0] o_token_kind;
    logic       o_content_valid;
    logic [7:0] o_content_byte;
    logic       o_token_complete;
    logic       o_lex_error;
    logic       o_text_finished;
    logic       o_last_of_run;

    json_token_lexer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_valid     (i_text_valid),
        .o_text_ready     (o_text_ready),
        .i_text_byte      (i_text_byte),
        .o_token_valid    (o_token_valid),
        .i_token_ready    (i_token_ready),
        .o_token_kind     (o_token_kind),
        .o_content_valid  (o_content_valid),
        .o_content_byte   (o_content_byte),
        .o_token_complete (o_token_complete),
        .o_lex_error      (o_lex_error),
        .o_text_finished  (o_text_finished),
        .o_last_of_run    (o_last_of_run)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    typedef struct {
        logic [7:0] text;
        int         n_typed;  // -1: take the expectation from the predictor
        t_result    r0;
        t_result    r1;
    } t_stim_row;

    // Predictor state
    t_mode      lexer_st   = MODE_IDLE;
    logic [1:0] lit_which  = LIT_TRUE;
    logic [2:0] lit_pos    = 3'd0;

    t_result    burst[$];
    t_result    pending_tokens[$];
    t_stim_row  stim_rows[$];
    logic [7:0] text_q[$];

    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    bit  hold_request   = 1'b0;
    int  held_cycles    = 0;
    int  bytes_sent     = 0;
    int  tokens_checked = 0;
    int  fail_count     = 0;

    function automatic t_result tok(input logic [3:0] kind, input logic comp,
                                    input logic err, input logic fin, input logic last);
        t_result r;
        r      = '0;
        r.kind = kind;
        r.comp = comp;
        r.err  = err;
        r.fin  = fin;
        r.last = last;
        return r;
    endfunction

    function automatic void emit(input logic [3:0] kind, input logic cv, input logic [7:0] cb,
                                 input logic comp, input logic err, input logic fin);
        t_result r;
        r.kind = kind;
        r.cv   = cv;
        r.cb   = cv ? cb : 8'd0;
        r.comp = comp;
        r.err  = err;
        r.fin  = fin;
        r.last = 1'b0;
        burst.push_back(r);
    endfunction

    function automatic string literal_word(input logic [1:0] which);
        if (which == LIT_FALSE) return "false";
        if (which == LIT_NULL) return "null";
        return "true";
    endfunction

    function automatic logic [3:0] literal_kind(input logic [1:0] which);
        if (which == LIT_FALSE) return KIND_FALSE;
        if (which == LIT_NULL) return KIND_NULL;
        return KIND_TRUE;
    endfunction

    function automatic bit is_num_byte(input logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_E ||
               b == CH_UPPER_E || b == CH_PLUS || b == CH_MINUS;
    endfunction

    // Lex a byte that arrives between tokens.
    function automatic void lex_between(input logic [7:0] b);
        lexer_st = MODE_IDLE;
        case (b)
            CH_NUL:                         emit(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
            CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
            CH_LBRACE:   emit(KIND_LBRACE, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            CH_RBRACE:   emit(KIND_RBRACE, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            CH_LBRACKET: emit(KIND_LBRACKET, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            CH_RBRACKET: emit(KIND_RBRACKET, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            CH_COLON:    emit(KIND_COLON, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            CH_COMMA:    emit(KIND_COMMA, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
            CH_QUOTE:    lexer_st = MODE_STRING;
            CH_T, CH_F, CH_N: begin
                lexer_st  = MODE_LITERAL;
                lit_which = (b == CH_T) ? LIT_TRUE : ((b == CH_F) ? LIT_FALSE : LIT_NULL);
                lit_pos   = 3'd1;
            end
            default: begin
                if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS) begin
                    lexer_st = MODE_NUMBER;
                    emit(KIND_NUMBER, 1'b1, b, 1'b0, 1'b0, 1'b0);
                end else begin
                    lexer_st = MODE_ERROR;
                    emit(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0);
                end
            end
        endcase
    endfunction

    // Advance the predictor by one text byte; its results land in burst.
    function automatic void lex_byte(input logic [7:0] b);
        string word;
        burst.delete();
        case (lexer_st)
            MODE_STRING: begin
                if (b == CH_QUOTE) begin
                    lexer_st = MODE_IDLE;
                    emit(KIND_STRING, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                end else if (b == CH_NUL) begin
                    emit(KIND_STRING, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    lex_between(b);
                end else begin
                    emit(KIND_STRING, 1'b1, b, 1'b0, 1'b0, 1'b0);
                end
            end
            MODE_NUMBER: begin
                if (is_num_byte(b)) begin
                    emit(KIND_NUMBER, 1'b1, b, 1'b0, 1'b0, 1'b0);
                end else begin
                    emit(KIND_NUMBER, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    lex_between(b);
                end
            end
            MODE_LITERAL: begin
                word = literal_word(lit_which);
                if (lit_pos < word.len() && b == word[lit_pos]) begin
                    lit_pos = lit_pos + 3'd1;
                    if (lit_pos >= word.len()) begin
                        lexer_st = MODE_IDLE;
                        emit(literal_kind(lit_which), 1'b0, 8'd0, 1'b1, 1'b0, 1'b0);
                    end
                end else begin
                    if (b == CH_NUL) lexer_st = MODE_IDLE;
                    else lexer_st = MODE_ERROR;
                    emit(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b1, b == CH_NUL);
                end
            end
            MODE_ERROR: begin
                if (b == CH_NUL) begin
                    lexer_st = MODE_IDLE;
                    emit(KIND_NONE, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
                end
            end
            default: lex_between(b);
        endcase
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    endfunction

    function automatic string fmt_tok(input t_result r);
        return $sformatf("kind=%0d cv=%0b cb=%02h comp=%0b err=%0b fin=%0b last=%0b",
                         r.kind, r.cv, r.cb, r.comp, r.err, r.fin, r.last);
    endfunction

    task automatic row_p(input logic [7:0] b);
        t_stim_row r;
        r.text    = b;
        r.n_typed = -1;
        r.r0      = NO_TOK;
        r.r1      = NO_TOK;
        stim_rows.push_back(r);
    endtask

    task automatic row_t(input logic [7:0] b, input int n, input t_result r0);
        t_stim_row r;
        r.text    = b;
        r.n_typed = n;
        r.r0      = r0;
        r.r1      = NO_TOK;
        stim_rows.push_back(r);
    endtask

    // Offer one byte starting at a falling edge; return at the falling edge after its beat.
    task automatic send_byte(input logic [7:0] b, input int n_typed,
                             input t_result r0, input t_result r1);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_text_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(negedge i_clk);
        end
        i_text_valid <= 1'b1;
        i_text_byte  <= b;
        do @(posedge i_clk); while (!o_text_ready);
        lex_byte(b);
        if (n_typed < 0) begin
            foreach (burst[k]) pending_tokens.push_back(burst[k]);
        end else begin
            if (n_typed > 0) pending_tokens.push_back(r0);
            if (n_typed > 1) pending_tokens.push_back(r1);
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Build random text: mostly well-formed tokens, some broken ones and noise.
    task automatic gen_text(input int target);
        string      word;
        string      num_set;
        int         len;
        int         cut;
        logic [7:0] c;
        num_set = "0123456789.eE+-";
        text_q.delete();
        while (text_q.size() < target) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    case ($urandom_range(0, 5))
                        0: text_q.push_back(CH_LBRACE);
                        1: text_q.push_back(CH_RBRACE);
                        2: text_q.push_back(CH_LBRACKET);
                        3: text_q.push_back(CH_RBRACKET);
                        4: text_q.push_back(CH_COLON);
                        default: text_q.push_back(CH_COMMA);
                    endcase
                end
                2: begin
                    case ($urandom_range(0, 3))
                        0: text_q.push_back(CH_SPACE);
                        1: text_q.push_back(CH_TAB);
                        2: text_q.push_back(CH_LF);
                        default: text_q.push_back(CH_CR);
                    endcase
                end
                3, 4: begin
                    text_q.push_back(CH_QUOTE);
                    len = $urandom_range(0, 6);
                    repeat (len) begin
                        c = 8'($urandom_range(1, 255));
                        if (c == CH_QUOTE) c = CH_TOP_BIT;
                        text_q.push_back(c);
                    end
                    // occasionally leave the string open at end of text
                    text_q.push_back(($urandom_range(0, 9) == 0) ? CH_NUL : CH_QUOTE);
                end
                5: begin
                    text_q.push_back(($urandom_range(0, 3) == 0) ? CH_MINUS
                                                                : 8'(CH_ZERO + $urandom_range(0, 9)));
                    len = $urandom_range(0, 5);
                    repeat (len) text_q.push_back(num_set[$urandom_range(0, num_set.len() - 1)]);
                end
                6, 7: begin
                    word = literal_word(2'($urandom_range(0, 2)));
                    if ($urandom_range(0, 4) != 0) begin
                        for (int k = 0; k < word.len(); k++) text_q.push_back(word[k]);
                    end else begin
                        cut = $urandom_range(1, word.len() - 1);
                        for (int k = 0; k < cut; k++) text_q.push_back(word[k]);
                        text_q.push_back(8'($urandom_range(0, 255)));
                    end
                end
                8: text_q.push_back(8'($urandom_range(0, 255)));
                default: text_q.push_back(CH_NUL);
            endcase
        end
    endtask

    // Receiver: random ready, plus one long hold-off on request.
    initial begin : token_sink
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_token_ready <= 1'b0;
                for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++)
                    @(negedge i_clk);
                hold_request = 1'b0;
            end
            i_token_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : token_check
        t_result got;
        t_result want;
        if (i_rst_n && o_token_valid && i_token_ready) begin
            got.kind = o_token_kind;
            got.cv   = o_content_valid;
            got.cb   = o_content_byte;
            got.comp = o_token_complete;
            got.err  = o_lex_error;
            got.fin  = o_text_finished;
            got.last = o_last_of_run;
            tokens_checked++;
            if (pending_tokens.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: unexpected beat: %s", $realtime, fmt_tok(got));
                fail_count++;
            end else begin
                want = pending_tokens.pop_front();
                if (got !== want) begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                 $realtime, fmt_tok(want), fmt_tok(got));
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #200000;
        $display("%0t: timeout, %0d beats still expected", $realtime, pending_tokens.size());
        $display("[json_token_lexer] ERROR");
        $finish;
    end

    initial begin : stimulus
        int directed_count;
        int drain_cycles;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        row_t(CH_NUL,      1, tok(KIND_NONE, 1'b0, 1'b0, 1'b1, 1'b1));
        row_t(CH_LBRACE,   1, tok(KIND_LBRACE, 1'b1, 1'b0, 1'b0, 1'b1));
        row_t(CH_SPACE,    0, NO_TOK);
        row_t(CH_QUOTE,    0, NO_TOK);
        row_p(CH_HIGH);
        row_t(CH_QUOTE,    1, tok(KIND_STRING, 1'b1, 1'b0, 1'b0, 1'b1));
        row_t(CH_COLON,    1, tok(KIND_COLON, 1'b1, 1'b0, 1'b0, 1'b1));
        row_p(CH_MINUS);
        row_p(CH_UPPER_E);
        row_p(CH_RBRACKET);        // closes the number, then a token of its own
        row_t(CH_T,        0, NO_TOK);
        row_p(CH_R);
        row_p(CH_U);
        row_p(CH_E);
        row_t(CH_COMMA,    1, tok(KIND_COMMA, 1'b1, 1'b0, 1'b0, 1'b1));
        row_t(CH_N,        0, NO_TOK);
        row_t(CH_NUL,      1, tok(KIND_NONE, 1'b0, 1'b1, 1'b1, 1'b1));
        row_t(CH_QUOTE,    0, NO_TOK);
        row_p(CH_NUL);             // end of text inside a string
        row_t(CH_LBRACKET, 1, tok(KIND_LBRACKET, 1'b1, 1'b0, 1'b0, 1'b1));
        row_p(CH_NINE);
        row_p(CH_NUL);             // end of text right after a number
        row_t(CH_AT,       1, tok(KIND_NONE, 1'b0, 1'b1, 1'b0, 1'b1));
        row_t(CH_TOP_BIT,  0, NO_TOK);
        row_t(CH_NUL,      1, tok(KIND_NONE, 1'b0, 1'b0, 1'b1, 1'b1));
        row_t(CH_RBRACE,   1, tok(KIND_RBRACE, 1'b1, 1'b0, 1'b0, 1'b1));

        send_idle_pct = 16;
        recv_idle_pct = 70;
        foreach (stim_rows[i])
            send_byte(stim_rows[i].text, stim_rows[i].n_typed, stim_rows[i].r0, stim_rows[i].r1);
        directed_count = bytes_sent;

        gen_text(PHASE_BYTES);
        foreach (text_q[i]) send_byte(text_q[i], -1, NO_TOK, NO_TOK);

        send_idle_pct = 70;
        recv_idle_pct = 16;
        gen_text(PHASE_BYTES);
        foreach (text_q[i]) send_byte(text_q[i], -1, NO_TOK, NO_TOK);

        // Flood the input while the receiver holds off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        gen_text(PHASE_BYTES);
        foreach (text_q[i]) send_byte(text_q[i], -1, NO_TOK, NO_TOK);
        i_text_valid <= 1'b0;

        drain_cycles = 0;
        while (pending_tokens.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(negedge i_clk);

        if (pending_tokens.size() != 0) begin
            $display("%0d expected beats never arrived", pending_tokens.size());
            fail_count += pending_tokens.size();
        end

        $display("Run covered %0d text bytes (%0d from the directed table), %0d token beats",
                 bytes_sent, directed_count, tokens_checked);
        $display("Receiver held off once for %0d cycles; %0d failures", HOLD_CYCLES, fail_count);
        if (fail_count == 0) begin
            $display("[json_token_lexer] OK");
        end else begin
            $display("[json_token_lexer] ERROR");
        end
        $finish;
    end

endmodule
